// File: hdl/ptc_pkg.sv
// Shared constants, codes and types of the ToT-to-charge calibration block.
`timescale 1ns / 1ps

package ptc_pkg;

	// Pixel matrix geometry and address width of the per-pixel stores.
	localparam int NUM_ROWS  = 192;
	localparam int NUM_COLS  = 400;
	localparam int PIX_DEPTH = NUM_ROWS * NUM_COLS;
	localparam int ADDR_W    = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;

	// Field widths fixed by the item format.
	localparam int COL_W  = 9;
	localparam int ROW_W  = 8;
	localparam int COEF_W = 32;
	localparam int TOT_W  = 4;
	localparam int VCAL_W = 12;

	// Iteration counts of the square root and of the final division.
	localparam int SQRT_STEPS = 64;
	localparam int DIV_STEPS  = VCAL_W;
	localparam int CNT_W      = $clog2(SQRT_STEPS);

	// Item modes.
	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_CONVERT = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_UNLOADED = 2'd1,
		STAT_BADFIT   = 2'd2,
		STAT_SAT      = 2'd3
	} ptc_status_t;

	// Datapath operations, one per controller step.
	typedef enum logic [4:0] {
		OP_IDLE,
		OP_CLEAR,
		OP_READ,
		OP_CHK,
		OP_AC,
		OP_Q,
		OP_P0,
		OP_P1,
		OP_P2,
		OP_P3,
		OP_SGN,
		OP_SQ,
		OP_NUM,
		OP_CHK2,
		OP_DIV,
		OP_DEND
	} ptc_op_t;

	// Controller states.
	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHK,
		ST_AC,
		ST_Q,
		ST_P0,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_SGN,
		ST_SQ,
		ST_NUM,
		ST_CHK2,
		ST_DIV,
		ST_DEND,
		ST_FIN
	} ptc_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		ptc_op_t op;
		logic    accept;
		logic    out_load;
	} ptc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;
		logic early;
	} ptc_sts_t;

endpackage

// File: hdl/ptc_ctrl.sv
// Controller state machine of the ToT-to-charge calibration block.
`timescale 1ns / 1ps

module ptc_ctrl
	import ptc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     mode,
	output logic     out_valid,
	input  logic     out_ready,
	input  ptc_sts_t sts,
	output ptc_cmd_t cmd
);

	ptc_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q;

	// State, step counter and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		cmd.op       = OP_IDLE;
		cmd.accept   = 1'b0;
		cmd.out_load = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (sts.clr_done)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && mode == MODE_CONVERT)
					state_d = ST_READ;
			end
			ST_READ: begin
				cmd.op  = OP_READ;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				cmd.op  = OP_CHK;
				state_d = sts.early ? ST_FIN : ST_AC;
			end
			ST_AC: begin
				cmd.op  = OP_AC;
				state_d = ST_Q;
			end
			ST_Q: begin
				cmd.op  = OP_Q;
				state_d = ST_P0;
			end
			ST_P0: begin
				cmd.op  = OP_P0;
				state_d = ST_P1;
			end
			ST_P1: begin
				cmd.op  = OP_P1;
				state_d = ST_P2;
			end
			ST_P2: begin
				cmd.op  = OP_P2;
				state_d = ST_P3;
			end
			ST_P3: begin
				cmd.op  = OP_P3;
				state_d = ST_SGN;
			end
			ST_SGN: begin
				cmd.op  = OP_SGN;
				cnt_d   = '0;
				state_d = sts.early ? ST_FIN : ST_SQ;
			end
			ST_SQ: begin
				cmd.op = OP_SQ;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SQRT_STEPS - 1))
					state_d = ST_NUM;
			end
			ST_NUM: begin
				cmd.op  = OP_NUM;
				state_d = ST_CHK2;
			end
			ST_CHK2: begin
				cmd.op  = OP_CHK2;
				cnt_d   = '0;
				state_d = sts.early ? ST_FIN : ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DIV;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1))
					state_d = ST_DEND;
			end
			ST_DEND: begin
				cmd.op  = OP_DEND;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				// Hand the result over once the output register is free.
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: hdl/ptc_datapath.sv
// Datapath of the ToT-to-charge calibration block: stores, multiplier, root and divider.
`timescale 1ns / 1ps

module ptc_datapath
	import ptc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  ptc_cmd_t                 cmd,
	output ptc_sts_t                 sts,
	input  logic                     mode,
	input  logic [COL_W-1:0]         pixel_col,
	input  logic [ROW_W-1:0]         pixel_row,
	input  logic signed [COEF_W-1:0] coef_a,
	input  logic signed [COEF_W-1:0] coef_b,
	input  logic signed [COEF_W-1:0] coef_c,
	input  logic signed [COEF_W-1:0] coef_t,
	input  logic [TOT_W-1:0]         tot_value,
	output logic [VCAL_W-1:0]        charge_vcal,
	output logic [1:0]               status
);

	// Per-pixel stores.
	logic [4*COEF_W-1:0] coef_mem [PIX_DEPTH];
	logic                mark_mem [PIX_DEPTH];

	logic [ADDR_W-1:0] idx_in, idx_q, clr_cnt_q;
	logic              inrange_in, inrange_q, clr_done_q, load_wr;
	logic [TOT_W-1:0]  tot_q;
	logic [4*COEF_W-1:0] coef_rd_q;
	logic              mark_rd_q;

	logic signed [COEF_W-1:0] a_c, b_c, c_c, t_c;
	logic signed [32:0]  mul_x, mul_y;
	logic signed [65:0]  prod_q;
	logic signed [63:0]  at_q, ac_q, n0_q, b32_c, tot32_c, q_c;
	logic [63:0]         qmag_q;
	logic [127:0]        acc_q, rad_q;
	logic [65:0]         rem_q;
	logic [67:0]         rem_sh_c, trial_c;
	logic [63:0]         root_q;
	logic signed [65:0]  num_s, num_q;
	logic [COEF_W-1:0]   a_mag;
	logic [48:0]         den_q;
	logic [65:0]         nmag_c;
	logic [66:0]         m2_c;
	logic [67:0]         t2_c, lim_c;
	logic [61:0]         drem_q;
	logic [60:0]         dsh_q;
	logic [VCAL_W-1:0]   quo_q, res_vcal_q;
	ptc_status_t         res_status_q;
	logic                early_c;

	// Pixel address and range check of the incoming item.
	assign inrange_in = (int'(pixel_col) < NUM_COLS) && (int'(pixel_row) < NUM_ROWS);
	assign idx_in     = inrange_in ?
		ADDR_W'(ADDR_W'(pixel_col) * ADDR_W'(NUM_ROWS) + ADDR_W'(pixel_row)) : '0;
	assign load_wr    = cmd.accept && mode == MODE_LOAD && inrange_in;

	// Clearing pass over the loaded marks after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_done_q <= 1'b0;
		end else if (cmd.op == OP_CLEAR && !clr_done_q) begin
			if (clr_cnt_q == ADDR_W'(PIX_DEPTH - 1))
				clr_done_q <= 1'b1;
			else
				clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Coefficient store: written by load items, read for convert items.
	always_ff @(posedge clk) begin
		if (load_wr)
			coef_mem[idx_in] <= {coef_t, coef_c, coef_b, coef_a};
		if (cmd.op == OP_READ)
			coef_rd_q <= coef_mem[idx_q];
	end

	// Loaded marks: cleared by the sweep, set by load items.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_CLEAR)
			mark_mem[clr_cnt_q] <= 1'b0;
		else if (load_wr)
			mark_mem[idx_in] <= 1'b1;
		if (cmd.op == OP_READ)
			mark_rd_q <= mark_mem[idx_q];
	end

	assign a_c = coef_rd_q[COEF_W-1:0];
	assign b_c = coef_rd_q[2*COEF_W-1:COEF_W];
	assign c_c = coef_rd_q[3*COEF_W-1:2*COEF_W];
	assign t_c = coef_rd_q[4*COEF_W-1:3*COEF_W];

	// Shared multiplier operand selection.
	always_comb begin
		unique case (cmd.op)
			OP_CHK: begin
				mul_x = {a_c[COEF_W-1], a_c};
				mul_y = {t_c[COEF_W-1], t_c};
			end
			OP_AC: begin
				mul_x = {a_c[COEF_W-1], a_c};
				mul_y = {c_c[COEF_W-1], c_c};
			end
			OP_P0: begin
				mul_x = {1'b0, qmag_q[31:0]};
				mul_y = {1'b0, qmag_q[31:0]};
			end
			OP_P1: begin
				mul_x = {1'b0, qmag_q[31:0]};
				mul_y = {1'b0, qmag_q[63:32]};
			end
			OP_P2: begin
				mul_x = {1'b0, qmag_q[63:32]};
				mul_y = {1'b0, qmag_q[63:32]};
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	// Terms of the discriminant at scale 2^32.
	assign b32_c   = {{16{b_c[COEF_W-1]}}, b_c, 16'd0};
	assign tot32_c = {28'd0, tot_q, 32'd0};
	assign q_c     = at_q + b32_c - tot32_c;

	// One step of the restoring square root.
	assign rem_sh_c = {rem_q, rad_q[127:126]};
	assign trial_c  = {2'b00, root_q, 2'b01};

	// Numerator, sign fold and rounding checks.
	assign num_s  = $signed({{2{n0_q[63]}}, n0_q}) + $signed({2'b00, root_q});
	assign a_mag  = a_c[COEF_W-1] ? COEF_W'(-a_c) : a_c;
	assign nmag_c = 66'(-num_q);
	assign m2_c   = {nmag_c, 1'b0};
	assign t2_c   = {1'b0, num_q, 1'b0} + {19'd0, den_q};
	assign lim_c  = {6'd0, den_q, 13'd0};

	// Early completion of a convert item.
	always_comb begin
		unique case (cmd.op)
			OP_CHK:  early_c = !inrange_q || !mark_rd_q || a_c == '0;
			OP_SGN:  early_c = acc_q[127];
			OP_CHK2: early_c = num_q[65] || t2_c >= lim_c;
			default: early_c = 1'b0;
		endcase
	end

	assign sts.early    = early_c;
	assign sts.clr_done = clr_done_q;

	// Working registers of the conversion.
	always_ff @(posedge clk) begin
		prod_q <= mul_x * mul_y;
		if (cmd.accept) begin
			idx_q     <= idx_in;
			inrange_q <= inrange_in;
			tot_q     <= tot_value;
		end
		unique case (cmd.op)
			OP_CHK: begin
				if (!inrange_q || !mark_rd_q) begin
					res_vcal_q   <= '0;
					res_status_q <= STAT_UNLOADED;
				end else if (a_c == '0) begin
					res_vcal_q   <= '0;
					res_status_q <= STAT_BADFIT;
				end
			end
			OP_AC: at_q <= prod_q[63:0];
			OP_Q: begin
				ac_q   <= prod_q[63:0];
				n0_q   <= at_q - b32_c + tot32_c;
				qmag_q <= q_c[63] ? 64'(-q_c) : q_c;
			end
			OP_P1: acc_q <= {{30{ac_q[63]}}, ac_q, 34'd0} + {64'd0, prod_q[63:0]};
			OP_P2: acc_q <= acc_q + {31'd0, prod_q[63:0], 33'd0};
			OP_P3: acc_q <= acc_q + {prod_q[63:0], 64'd0};
			OP_SGN: begin
				if (acc_q[127]) begin
					res_vcal_q   <= '0;
					res_status_q <= STAT_BADFIT;
				end
				rad_q  <= acc_q;
				rem_q  <= '0;
				root_q <= '0;
			end
			OP_SQ: begin
				rad_q <= {rad_q[125:0], 2'b00};
				if (rem_sh_c >= trial_c) begin
					rem_q  <= 66'(rem_sh_c - trial_c);
					root_q <= {root_q[62:0], 1'b1};
				end else begin
					rem_q  <= rem_sh_c[65:0];
					root_q <= {root_q[62:0], 1'b0};
				end
			end
			OP_NUM: begin
				num_q <= a_c[COEF_W-1] ? -num_s : num_s;
				den_q <= {a_mag, 17'd0};
			end
			OP_CHK2: begin
				if (num_q[65]) begin
					res_vcal_q   <= '0;
					res_status_q <= (m2_c >= {18'd0, den_q}) ? STAT_SAT : STAT_OK;
				end else if (t2_c >= lim_c) begin
					res_vcal_q   <= '1;
					res_status_q <= STAT_SAT;
				end
				drem_q <= t2_c[61:0];
				dsh_q  <= {den_q, 12'd0};
				quo_q  <= '0;
			end
			OP_DIV: begin
				dsh_q <= {1'b0, dsh_q[60:1]};
				if (drem_q >= {1'b0, dsh_q}) begin
					drem_q <= drem_q - {1'b0, dsh_q};
					quo_q  <= {quo_q[VCAL_W-2:0], 1'b1};
				end else begin
					quo_q  <= {quo_q[VCAL_W-2:0], 1'b0};
				end
			end
			OP_DEND: begin
				res_vcal_q   <= quo_q;
				res_status_q <= STAT_OK;
			end
			default: ;
		endcase
		if (cmd.out_load) begin
			charge_vcal <= res_vcal_q;
			status      <= res_status_q;
		end
	end

endmodule

// File: hdl/pixel_tot_to_charge_calibration.sv
// Top level of the per-pixel ToT-to-charge calibration block.
`timescale 1ns / 1ps

// Converts a pixel's ToT into injected charge (vcal) by inverting its surrogate
// calibration function, with per-pixel coefficients a, b, c and t (signed Q16.16)
// held in an on-chip store addressed by col*NUM_ROWS+row. A load item writes a
// pixel's coefficients as it is taken and gives no result. A convert item is
// mostly the 64-step bit-serial square root of the 128-bit discriminant, then a
// 12-step division; partial products go through one shared 33x33 multiplier.
// One item is worked on at a time, and the next is taken while a finished result
// waits in the output register. After reset the loaded marks are swept clear, one
// pixel a cycle (all 76800 pixels), before the first item is taken.
module pixel_tot_to_charge_calibration
	import ptc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     mode,
	input  logic [COL_W-1:0]         pixel_col,
	input  logic [ROW_W-1:0]         pixel_row,
	input  logic signed [COEF_W-1:0] coef_a,
	input  logic signed [COEF_W-1:0] coef_b,
	input  logic signed [COEF_W-1:0] coef_c,
	input  logic signed [COEF_W-1:0] coef_t,
	input  logic [TOT_W-1:0]         tot_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [VCAL_W-1:0]        charge_vcal,
	output logic [1:0]               status
);

	ptc_cmd_t cmd;
	ptc_sts_t sts;

	// Sequencer.
	ptc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Stores and arithmetic.
	ptc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.pixel_col   (pixel_col),
		.pixel_row   (pixel_row),
		.coef_a      (coef_a),
		.coef_b      (coef_b),
		.coef_c      (coef_c),
		.coef_t      (coef_t),
		.tot_value   (tot_value),
		.charge_vcal (charge_vcal),
		.status      (status)
	);

`ifndef SYNTHESIS
	// A result is never loaded over one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("result loaded over a pending one");

	// An accepted convert item keeps the input closed on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && mode == MODE_CONVERT) |=> !in_ready)
		else $error("input reopened during a conversion");

	// Unloaded pixels and bad fits report zero charge.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STAT_UNLOADED || status == STAT_BADFIT))
			|-> charge_vcal == '0)
		else $error("nonzero charge with an error status");

	// A saturated result is either the floor or the ceiling.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_SAT) |-> (charge_vcal == '0 || charge_vcal == '1))
		else $error("saturated result not at a limit");
`endif

endmodule
